### src/adcvm_pkg.sv
// Shared types, constants and helper functions for the ADC averaging voltmeter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package adcvm_pkg;

  // Batch size of the running average.
  localparam int SamplesPerAverage = 5;

  localparam int SampleW = 10;
  localparam int AvgW    = SampleW;
  localparam int SegW    = 7;
  localparam int VoltW   = 6;
  localparam int DigitW  = 4;

  // Largest ADC code; it is also the divisor of the tenths scaling.
  localparam int AdcFullScale = 1023;
  localparam int VoltScale    = 33;

  // Sum and count registers sized to the batch.
  localparam int SumW = $clog2(SamplesPerAverage * AdcFullScale + 1);
  localparam int CntW = $clog2(SamplesPerAverage + 1);

  // Exact reciprocal for sum / SamplesPerAverage over SumW-bit sums.
  localparam int DivL     = $clog2(SamplesPerAverage);
  localparam int DivSh    = SumW + DivL;
  localparam int RecipW   = DivSh + 1;
  localparam int Recip    = ((2 ** DivSh) + SamplesPerAverage - 1) / SamplesPerAverage;
  localparam int ProdW    = SumW + RecipW;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef enum logic {
    SEL_UNITS = 1'b0,
    SEL_TENS  = 1'b1
  } digit_sel_e;

  // Per-cycle step of the work stage.
  typedef struct packed {
    logic sample_fire;
    logic tick_fire;
  } step_t;

  // Display word handed back to the output register.
  typedef struct packed {
    logic [SegW-1:0] segments;
    logic            digit_select;
  } disp_t;

  // Seven-segment pattern, bit 0 = segment a .. bit 6 = segment g.
  function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

### src/adcvm_in_if.sv
// Input channel of the voltmeter: valid/ready handshake with opcode and sample.
// Depends on adcvm_pkg.
`timescale 1ns / 1ps

interface adcvm_in_if;
  import adcvm_pkg::*;

  logic               valid;
  logic               ready;
  opcode_e            opcode;
  logic [SampleW-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

### src/adcvm_out_if.sv
// Output channel of the voltmeter: valid/ready handshake with segments and digit select.
// Depends on adcvm_pkg.
`timescale 1ns / 1ps

interface adcvm_out_if;
  import adcvm_pkg::*;

  logic            valid;
  logic            ready;
  logic [SegW-1:0] segments;
  logic            digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

### src/adcvm_accum.sv
// Sample accumulator: sums a batch of ADC samples and holds the batch average.
// Depends on adcvm_pkg.
`timescale 1ns / 1ps

module adcvm_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  adcvm_pkg::step_t            step_i,
  input  logic [adcvm_pkg::SampleW-1:0] sample_i,
  output logic [adcvm_pkg::AvgW-1:0]  avg_o
);
  import adcvm_pkg::*;

  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AvgW-1:0]  avg_q, avg_d;
  logic [SumW-1:0]  sum_next;
  logic [ProdW-1:0] prod;
  logic             batch_done;

  assign sum_next   = sum_q + SumW'(sample_i);
  assign batch_done = (cnt_q == CntW'(SamplesPerAverage - 1));
  // Divide by the batch size through the exact reciprocal.
  assign prod       = ProdW'(sum_next) * ProdW'(Recip);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    avg_d = avg_q;
    if (step_i.sample_fire) begin
      if (batch_done) begin
        avg_d = prod[DivSh +: AvgW];
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      avg_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      avg_q <= avg_d;
    end
  end

  assign avg_o = avg_q;

endmodule

### src/adcvm_display.sv
// Display encoder: scales the held average to tenths of a volt, splits it into
// two digits and encodes the current one. Depends on adcvm_pkg.
`timescale 1ns / 1ps

module adcvm_display (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  adcvm_pkg::step_t           step_i,
  input  logic [adcvm_pkg::AvgW-1:0] avg_i,
  output adcvm_pkg::disp_t           disp_o
);
  import adcvm_pkg::*;

  localparam int ScaledW = 16;
  localparam int Bias    = AdcFullScale / 2;

  digit_sel_e          show_q, show_d;
  logic [ScaledW-1:0]  scaled;
  logic [VoltW-1:0]    quot0;
  logic [AvgW:0]       rem;
  logic [VoltW-1:0]    volt;
  logic [9:0]          tens_prod;
  logic [DigitW-1:0]   high_digit;
  logic [VoltW-1:0]    tens_x10;
  logic [DigitW-1:0]   low_digit;
  logic [DigitW-1:0]   digit;

  // avg*33 + 511, then divide by 1023: x = q0*1024 + r0 gives x = q0*1023 + (r0 + q0).
  assign scaled = (ScaledW'(avg_i) << 5) + ScaledW'(avg_i) + ScaledW'(Bias);
  assign quot0  = scaled[ScaledW-1 -: VoltW];
  assign rem    = (AvgW+1)'(scaled[AvgW-1:0]) + (AvgW+1)'(quot0);
  assign volt   = (rem >= (AvgW+1)'(AdcFullScale)) ? quot0 + VoltW'(1) : quot0;

  // Tens by reciprocal (v*13 >> 7, exact for the voltage range), units by difference.
  assign tens_prod  = 10'(volt) * 10'd13;
  assign high_digit = DigitW'(tens_prod[9:7]);
  assign tens_x10   = (VoltW'(high_digit) << 3) + (VoltW'(high_digit) << 1);
  assign low_digit  = DigitW'(volt - tens_x10);
  assign digit      = (show_q == SEL_TENS) ? high_digit : low_digit;

  assign disp_o.segments     = seg_code(digit);
  assign disp_o.digit_select = show_q;

  always_comb begin
    show_d = show_q;
    if (step_i.tick_fire) begin
      show_d = (show_q == SEL_TENS) ? SEL_UNITS : SEL_TENS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_q <= SEL_UNITS;
    end else begin
      show_q <= show_d;
    end
  end

endmodule

### src/adc_average_voltmeter_display_unit.sv
// ADC averaging voltmeter with a multiplexed two-digit seven-segment display.
// A refresh tick's word is loaded into the output register as the tick retires.
// Throughput: one item per cycle unless a tick waits for room in the output register;
// the accumulator and the display encoder work straight from the input register.
// Reset (asynchronous, active low): sum, count and held average cleared, low digit first.
`timescale 1ns / 1ps

module adc_average_voltmeter_display_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  adcvm_in_if.sink     in_i,
  adcvm_out_if.source  out_o
);
  import adcvm_pkg::*;

  // Input register: holds the accepted word until the work stage can retire it.
  logic               s1_valid_q, s1_valid_d;
  opcode_e            s1_op_q;
  logic [SampleW-1:0] s1_sample_q;

  // Output register: holds a display word until the sink takes it.
  logic               out_valid_q, out_valid_d;
  disp_t              out_word_q;

  logic               out_free;
  logic               s1_adv;
  logic               in_fire;
  step_t              step;
  logic [AvgW-1:0]    avg;
  disp_t              disp;

  // A sample retires without an output slot; a tick needs room in the output register.
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && ((s1_op_q == OP_SAMPLE) || out_free);
  assign in_fire  = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || s1_adv;

  assign step.sample_fire = s1_adv && (s1_op_q == OP_SAMPLE);
  assign step.tick_fire   = s1_adv && (s1_op_q == OP_TICK);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the payload on acceptance only; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_i.opcode;
      s1_sample_q <= in_i.sample;
    end
  end

  adcvm_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (s1_sample_q),
    .avg_o    (avg)
  );

  adcvm_display u_display (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .avg_i  (avg),
    .disp_o (disp)
  );

  // Load on a retiring tick, drop once the sink has taken the word.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step.tick_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.tick_fire) begin
      out_word_q <= disp;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.segments     = out_word_q.segments;
  assign out_o.digit_select = out_word_q.digit_select;

endmodule

### tb/adcvm_checker.sv
// Scoreboard for the voltmeter: watches both channels, predicts each display word and compares.
// Depends on adcvm_pkg and the adcvm_in_if / adcvm_out_if channel interfaces.
`timescale 1ns / 1ps

module adcvm_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  adcvm_in_if   in_mon,
  adcvm_out_if  out_mon,
  output int    fail_count_o,
  output int    outstanding_o
);
  import adcvm_pkg::*;

  localparam int RoundBias   = AdcFullScale / 2;
  localparam int ReportLimit = 10;

  logic [SumW-1:0]  batch_sum;
  logic [CntW-1:0]  batch_fill;
  logic [VoltW-1:0] shown_tenths;
  digit_sel_e       next_digit;
  disp_t            display_q[$];

  function automatic logic [SegW-1:0] glyph_for(input int unsigned digit);
    case (digit)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  // Fold one accepted word into the running state; a tick queues its display word.
  task automatic absorb_word(input opcode_e op, input logic [SampleW-1:0] value);
    int unsigned total;
    int unsigned fill;
    int unsigned mean;
    int unsigned tenths;
    int unsigned digit;
    disp_t       word;
    if (op == OP_SAMPLE) begin
      total = int'(batch_sum) + int'(value);
      fill  = int'(batch_fill) + 1;
      if (fill >= SamplesPerAverage) begin
        mean         = total / SamplesPerAverage;
        tenths       = (mean * VoltScale + RoundBias) / AdcFullScale;
        shown_tenths = tenths[VoltW-1:0];
        batch_sum    = '0;
        batch_fill   = '0;
      end else begin
        batch_sum  = total[SumW-1:0];
        batch_fill = fill[CntW-1:0];
      end
    end else begin
      if (next_digit == SEL_TENS) digit = (int'(shown_tenths) / 10) % 10;
      else                        digit = int'(shown_tenths) % 10;
      word.segments     = glyph_for(digit);
      word.digit_select = next_digit;
      display_q.push_back(word);
      next_digit = (next_digit == SEL_UNITS) ? SEL_TENS : SEL_UNITS;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    disp_t want;
    if (!rst_ni) begin
      batch_sum     = '0;
      batch_fill    = '0;
      shown_tenths  = '0;
      next_digit    = SEL_UNITS;
      display_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_word(in_mon.opcode, in_mon.sample);
      if (out_mon.valid && out_mon.ready) begin
        if (display_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportLimit)
            $display("%0t: unexpected display word seg=%h sel=%b", $realtime,
                     out_mon.segments, out_mon.digit_select);
        end else begin
          want = display_q.pop_front();
          if (out_mon.segments !== want.segments ||
              out_mon.digit_select !== want.digit_select) begin
            fail_count_o++;
            if (fail_count_o <= ReportLimit)
              $display("%0t: display word mismatch: expected seg=%h sel=%b, got seg=%h sel=%b",
                       $realtime, want.segments, want.digit_select,
                       out_mon.segments, out_mon.digit_select);
          end
        end
      end
      outstanding_o = display_q.size();
    end
  end

endmodule

### tb/adc_average_voltmeter_display_unit_tb.sv
// Top of the voltmeter testbench: clock, reset, stimulus, output back-pressure and verdict.
// Depends on adcvm_pkg, the channel interfaces, the block itself and adcvm_checker.
`timescale 1ns / 1ps

module adc_average_voltmeter_display_unit_tb;
  import adcvm_pkg::*;

  localparam int WatchdogLimit = 4000;  // cycles with no word moving on either channel
  localparam int HoldCycles    = 300;   // length of the one long output hold-off
  localparam int DrainCycles   = 20;    // quiet cycles after the last display word
  localparam int DrainLimit    = 50000;
  localparam int PhaseItems    = 265;
  localparam int PressureItems = 60;
  localparam int TickPct       = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  adcvm_in_if  in_ch ();
  adcvm_out_if out_ch ();

  int fail_count;
  int outstanding;

  // Idling knobs: the sender's is read only by the stimulus process,
  // the receiver's and the hold request are handed over with nonblocking writes.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  logic hold_armed  = 1'b0;
  int held_for      = 0;
  int quiet_cycles  = 0;

  // Running state of the random sample generator.
  int unsigned samples_sent = 0;
  int unsigned batch_level  = 0;

  adc_average_voltmeter_display_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  adcvm_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: once armed, hold ready low for a long stretch so that the block
  // fills up and stalls its input; otherwise stall at random at the current rate.
  always @(posedge clk_i) begin
    if (hold_armed && held_for < HoldCycles) begin
      out_ch.ready <= 1'b0;
      held_for     <= held_for + 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("adc_average_voltmeter_display_unit_tb failed");
        $finish;
      end
    end
  end

  // Offer one word, idling first at the sender's rate, and return at the edge
  // where it is taken. Valid stays high when the next word follows at once.
  task automatic send_word(input opcode_e op, input logic [SampleW-1:0] value);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= SampleW'($urandom_range(0, AdcFullScale));
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sample <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // A tick carries a random (ignored) sample field. Samples mostly cluster
  // round a level chosen per batch, so the averages sweep the whole 0..33 range;
  // the rest are rail values or fully random codes.
  task automatic send_random_word();
    int pick;
    int lvl;
    logic [SampleW-1:0] value;
    if ($urandom_range(0, 99) < TickPct) begin
      send_word(OP_TICK, SampleW'($urandom_range(0, AdcFullScale)));
    end else begin
      if (samples_sent % SamplesPerAverage == 0) batch_level = $urandom_range(0, AdcFullScale);
      pick = $urandom_range(0, 7);
      case (pick)
        0: value = '0;
        1: value = SampleW'(AdcFullScale);
        2: value = SampleW'($urandom_range(0, AdcFullScale));
        default: begin
          lvl = int'(batch_level) + int'($urandom_range(0, 16)) - 8;
          if (lvl < 0) lvl = 0;
          if (lvl > AdcFullScale) lvl = AdcFullScale;
          value = SampleW'(lvl);
        end
      endcase
      samples_sent++;
      send_word(OP_SAMPLE, value);
    end
  endtask

  task automatic send_batch(input logic [SampleW-1:0] value);
    repeat (SamplesPerAverage) send_word(OP_SAMPLE, value);
  endtask

  initial begin
    int waited;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_SAMPLE;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the display shows two zero digits before any batch completes.
    send_word(OP_TICK, '0);
    send_word(OP_TICK, SampleW'(AdcFullScale));
    // Full-scale batch: largest average, 3.3 V, both digits three.
    send_batch(SampleW'(AdcFullScale));
    send_word(OP_TICK, '0);
    send_word(OP_TICK, '0);
    // Mid-scale batch gives 1.7 V; an odd third tick leaves the high digit next.
    send_batch(SampleW'(512));
    send_word(OP_TICK, '0);
    send_word(OP_TICK, '0);
    send_word(OP_TICK, '0);
    // Zero samples plus one large code: average just on the rounding edge to 0.1 V,
    // shown as a high digit of zero.
    repeat (SamplesPerAverage - 1) send_word(OP_SAMPLE, '0);
    send_word(OP_SAMPLE, SampleW'(80));
    send_word(OP_TICK, SampleW'(AdcFullScale));

    // Pressure: hold the output off for a long stretch while ticks keep coming.
    hold_armed <= 1'b1;
    repeat (PressureItems) send_word(OP_TICK, SampleW'($urandom_range(0, AdcFullScale)));

    // Random phases: no idling, idle sender, stalling receiver, both lightly.
    repeat (PhaseItems) send_random_word();
    src_idle_pct = 79;
    repeat (PhaseItems) send_random_word();
    src_idle_pct = 0;
    snk_stall_pct <= 79;
    repeat (PhaseItems) send_random_word();
    src_idle_pct = 12;
    snk_stall_pct <= 12;
    repeat (PhaseItems) send_random_word();
    in_ch.valid <= 1'b0;

    // Drain: wait for every expected word, then let the pipeline settle.
    waited = 0;
    while (outstanding != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("adc_average_voltmeter_display_unit_tb passed");
    end else begin
      $display("adc_average_voltmeter_display_unit_tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/adcvm_pkg.sv
src/adcvm_in_if.sv
src/adcvm_out_if.sv
src/adcvm_accum.sv
src/adcvm_display.sv
src/adc_average_voltmeter_display_unit.sv
tb/adcvm_checker.sv
tb/adc_average_voltmeter_display_unit_tb.sv
